// ===== hw/rtl/tcpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and constants of the two-class priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tcpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_LIMIT    = 1024;

  localparam int ID_W    = 10;
  localparam int ADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CNTO_W  = 7;
  localparam int ENTRY_W = ID_W + 1;

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DEPART = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_SHIFT_UP,
    ST_SHIFT_DN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            urgent;
    logic            entry_class;
    logic [ID_W-1:0] flight_id;
    cmd_e            command;
  } item_t;

  typedef struct packed {
    logic              urg;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic [CNTO_W-1:0] urgent_count;
    logic [CNTO_W-1:0] entry_count;
    logic              id_present;
    logic [ID_W-1:0]   departed_id;
    logic              success;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcpq_ram.sv =====
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Command sequencer: walks the slot RAM to find the ID, then shifts entries
// to open or close a gap, and keeps the entry and urgent counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tcpq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire tcpq_pkg::item_t      item_in,
  input  wire logic                 queue_type,
  input  wire logic                 res_ready,
  output logic                      res_valid,
  output tcpq_pkg::result_t         res,
  output tcpq_pkg::mem_req_t        mem_req,
  input  wire tcpq_pkg::entry_t     mem_rdata
);

  tcpq_pkg::state_e state, state_next;
  tcpq_pkg::item_t  item;

  logic [tcpq_pkg::CNT_W-1:0]  occ;
  logic [tcpq_pkg::CNT_W-1:0]  ucnt;
  logic [tcpq_pkg::CNT_W-1:0]  rd_idx;
  logic                        pend;
  logic [tcpq_pkg::ADDR_W-1:0] pend_addr;
  logic                        found;
  logic [tcpq_pkg::ADDR_W-1:0] pos;
  logic                        del_urg;
  logic [tcpq_pkg::ID_W-1:0]   head_id;
  logic                        head_urg;
  logic                        ok;
  logic [tcpq_pkg::ID_W-1:0]   departed;

  logic                        issue;
  logic                        hit;
  logic                        id_ok;
  logic                        add_ok;
  logic [tcpq_pkg::CNT_W-1:0]  ins_pos;

  assign id_ok = (item.flight_id != '0) &&
                 (32'(item.flight_id) < tcpq_pkg::ID_LIMIT);
  assign hit = pend && (mem_rdata.id == item.flight_id);
  assign add_ok = id_ok && !found && (item.entry_class == queue_type) &&
                  (32'(occ) < tcpq_pkg::QUEUE_DEPTH);
  assign ins_pos = item.urgent ? ucnt : occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcpq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    issue          = 1'b0;
    mem_req        = '0;
    mem_req.wdata  = mem_rdata;
    res.success      = ok;
    res.departed_id  = departed;
    res.id_present   = id_ok && found;
    res.entry_count  = tcpq_pkg::CNTO_W'(occ);
    res.urgent_count = tcpq_pkg::CNTO_W'(ucnt);
    unique case (state)
      tcpq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = tcpq_pkg::ST_SEARCH;
        end
      end
      tcpq_pkg::ST_SEARCH: begin
        issue         = rd_idx < occ;
        mem_req.re    = issue;
        mem_req.raddr = rd_idx[tcpq_pkg::ADDR_W-1:0];
        if (!issue && !pend) begin
          state_next = tcpq_pkg::ST_DECIDE;
        end
      end
      tcpq_pkg::ST_DECIDE: begin
        state_next = tcpq_pkg::ST_DONE;
        unique case (item.command)
          tcpq_pkg::CMD_ADD: begin
            if (add_ok) begin
              state_next = tcpq_pkg::ST_SHIFT_DN;
            end
          end
          tcpq_pkg::CMD_REMOVE: begin
            if (found) begin
              state_next = tcpq_pkg::ST_SHIFT_UP;
            end
          end
          tcpq_pkg::CMD_DEPART: begin
            if (occ != '0) begin
              state_next = tcpq_pkg::ST_SHIFT_UP;
            end
          end
          default: begin
            state_next = tcpq_pkg::ST_DONE;
          end
        endcase
      end
      tcpq_pkg::ST_SHIFT_UP: begin
        // close the gap: entry i+1 moves to i
        issue         = rd_idx < occ;
        mem_req.re    = issue;
        mem_req.raddr = rd_idx[tcpq_pkg::ADDR_W-1:0];
        mem_req.we    = pend;
        mem_req.waddr = pend_addr - 1'b1;
        if (!issue && !pend) begin
          state_next = tcpq_pkg::ST_DONE;
        end
      end
      tcpq_pkg::ST_SHIFT_DN: begin
        // open a gap at pos: entry i moves to i+1, tail first
        issue         = rd_idx > tcpq_pkg::CNT_W'(pos);
        mem_req.re    = issue;
        mem_req.raddr = tcpq_pkg::ADDR_W'(rd_idx - 1'b1);
        mem_req.we    = pend;
        mem_req.waddr = pend_addr + 1'b1;
        if (!issue && !pend) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = pos;
          mem_req.wdata.id    = item.flight_id;
          mem_req.wdata.urg   = item.urgent;
          state_next          = tcpq_pkg::ST_DONE;
        end
      end
      tcpq_pkg::ST_DONE: begin
        res_valid = res_ready;
        if (res_ready) begin
          state_next = tcpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcpq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      ucnt <= '0;
      pend <= 1'b0;
    end else begin
      pend <= issue;
      case (state)
        tcpq_pkg::ST_SHIFT_UP: begin
          if (!issue && !pend) begin
            occ  <= occ - 1'b1;
            ucnt <= ucnt - tcpq_pkg::CNT_W'(del_urg);
          end
        end
        tcpq_pkg::ST_SHIFT_DN: begin
          if (!issue && !pend) begin
            occ  <= occ + 1'b1;
            ucnt <= ucnt + tcpq_pkg::CNT_W'(item.urgent);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= mem_req.raddr;
    case (state)
      tcpq_pkg::ST_IDLE: begin
        item     <= item_in;
        rd_idx   <= '0;
        found    <= 1'b0;
        ok       <= 1'b0;
        departed <= '0;
      end
      tcpq_pkg::ST_SEARCH: begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (pend && pend_addr == '0) begin
          head_id  <= mem_rdata.id;
          head_urg <= mem_rdata.urg;
        end
        if (hit) begin
          found   <= 1'b1;
          pos     <= pend_addr;
          del_urg <= mem_rdata.urg;
        end
      end
      tcpq_pkg::ST_DECIDE: begin
        unique case (item.command)
          tcpq_pkg::CMD_ADD: begin
            ok     <= add_ok;
            pos    <= tcpq_pkg::ADDR_W'(ins_pos);
            rd_idx <= occ;
          end
          tcpq_pkg::CMD_REMOVE: begin
            ok     <= found;
            rd_idx <= tcpq_pkg::CNT_W'(pos) + 1'b1;
          end
          tcpq_pkg::CMD_DEPART: begin
            if (occ != '0) begin
              ok       <= 1'b1;
              departed <= head_id;
              del_urg  <= head_urg;
              rd_idx   <= tcpq_pkg::CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      tcpq_pkg::ST_SHIFT_UP: begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
      end
      tcpq_pkg::ST_SHIFT_DN: begin
        if (issue) begin
          rd_idx <= rd_idx - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_ucnt_le_occ: assert property (@(posedge clk) disable iff (rst)
    ucnt <= occ) else $error("urgent count above entry count");

  a_occ_le_depth: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= tcpq_pkg::QUEUE_DEPTH) else $error("entry count above depth");

  a_no_wr_in_search: assert property (@(posedge clk) disable iff (rst)
    (state == tcpq_pkg::ST_SEARCH) |-> !mem_req.we)
    else $error("slot write during search");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("shift reads and writes the same slot");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (state == tcpq_pkg::ST_IDLE) && !res_valid)
    else $error("result issued twice");

endmodule

`default_nettype wire

// ===== hw/rtl/two_class_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_class_priority_queue_unit
// Ordered queue of IDs with an urgent class kept ahead of the regular class.
//
//   channel  dir  payload (low bit up)
//   s_axis   in   command[1:0] flight_id[11:2] entry_class[12] urgent[13]
//   m_axis   out  success[0] departed_id[10:1] id_present[11]
//                 entry_count[18:12] urgent_count[25:19]
//   cfg      in   queue_type
//
// A command walks the slot RAM once to look up the ID, then shifts the tail
// to open or close a slot, all through the single read port. One command is
// in flight at a time; a finished result waits in the output register while
// the next beat is taken. Reset empties the queue at once; slot contents are
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module two_class_priority_queue_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // command, flight_id, entry_class, urgent
  input  wire logic [tcpq_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // success, departed_id, id_present, entry_count, urgent_count
  output logic      [tcpq_pkg::M_DATA_W-1:0]   m_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_wr_data
);

  logic               queue_type;
  logic               res_ready;
  logic               res_valid;
  tcpq_pkg::result_t  res;
  tcpq_pkg::item_t    item;
  tcpq_pkg::mem_req_t mem_req;
  tcpq_pkg::entry_t   mem_rdata;

  assign item      = tcpq_pkg::item_t'(s_tdata[$bits(tcpq_pkg::item_t)-1:0]);
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_type <= 1'b0;
    end else if (cfg_wr_en) begin
      queue_type <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= tcpq_pkg::M_DATA_W'(res);
    end
  end

  tcpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .item_in    (item),
    .queue_type (queue_type),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  tcpq_ram #(
    .WIDTH (tcpq_pkg::ENTRY_W),
    .DEPTH (tcpq_pkg::QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
